@@ rtl/mawg_pkg.sv @@
// ----------------------------------------------------------------------------
// mawg_pkg: shared types and constants for the address walk generator
// Field widths, register indexes, walk modes and the xorshift step.
// ----------------------------------------------------------------------------
package mawg_pkg;

    localparam int DRAW_BITS       = 64;
    localparam int ADDR_BITS       = 64;
    localparam int WORD_BITS       = 32;
    localparam int SIZE_FIELD_BITS = 33;
    localparam int PROB_BITS       = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CNT_BITS        = $clog2(DRAW_BITS);
    localparam int ALIGN_BITS      = 3;
    localparam int WORD_SHIFT      = 3;

    localparam int XS_SHIFT_A = 12;
    localparam int XS_SHIFT_B = 25;
    localparam int XS_SHIFT_C = 27;

    localparam logic [DRAW_BITS-1:0]       MIX_MULT           = 64'h2545_F491_4F6C_DD1D;
    localparam logic [DRAW_BITS-1:0]       SEED_RESET         = 64'd1;
    localparam logic [SIZE_FIELD_BITS-1:0] REGION_WORDS_RESET = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        MODE_INC  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_RAND = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REGION_BASE  = 3'd0,
        REG_REGION_WORDS = 3'd1,
        REG_SEED_INIT    = 3'd2,
        REG_THR_INC      = 3'd3,
        REG_THR_DEC      = 3'd4,
        REG_THR_RAND     = 3'd5
    } t_cfg_reg;

    function automatic logic [DRAW_BITS-1:0] xs_step(input logic [DRAW_BITS-1:0] s);
        logic [DRAW_BITS-1:0] v;
        begin
            v = s ^ (s >> XS_SHIFT_A);
            v = v ^ (v << XS_SHIFT_B);
            v = v ^ (v >> XS_SHIFT_C);
            return v;
        end
    endfunction

    // a zero seed would lock the generator
    function automatic logic [DRAW_BITS-1:0] seed_value(input logic [DRAW_BITS-1:0] s);
        return (s == '0) ? SEED_RESET : s;
    endfunction

endpackage

@@ rtl/mawg_intf.sv @@
// ----------------------------------------------------------------------------
// mawg_intf: valid/ready channels of the address walk generator
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface mawg_in_if;
    logic                            valid;
    logic                            ready;
    logic [mawg_pkg::WORD_BITS-1:0]  prev_word_index;

    modport source (output valid, output prev_word_index, input ready);
    modport sink   (input valid, input prev_word_index, output ready);
endinterface

interface mawg_out_if;
    logic                            valid;
    logic                            ready;
    logic [mawg_pkg::WORD_BITS-1:0]  next_word_index;
    logic [mawg_pkg::ADDR_BITS-1:0]  next_address;
    logic [1:0]                      next_mode;

    modport source (output valid, output next_word_index, output next_address,
                    output next_mode, input ready);
    modport sink   (input valid, input next_word_index, input next_address,
                    input next_mode, output ready);
endinterface

interface mawg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mawg_pkg::CFG_IDX_BITS-1:0] index;
    logic [mawg_pkg::DRAW_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mawg_mix_mul.sv @@
// ----------------------------------------------------------------------------
// mawg_mix_mul: bit-serial multiply by the xorshift64* constant
// One multiplier bit per cycle, product modulo 2^64, done pulse at the end.
// ----------------------------------------------------------------------------
module mawg_mix_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mawg_pkg::DRAW_BITS-1:0] i_operand,
    output logic                           o_done,
    output logic [mawg_pkg::DRAW_BITS-1:0] o_product
);
    import mawg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DRAW_BITS-1:0] r_mcand;
    logic [DRAW_BITS-1:0] r_mplier;
    logic [DRAW_BITS-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy   <= 1'b1;
            r_done   <= 1'b0;
            r_cnt    <= '0;
            r_mcand  <= i_operand;
            r_mplier <= MIX_MULT;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            r_cnt    <= r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(DRAW_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

@@ rtl/mawg_mod_unit.sv @@
// ----------------------------------------------------------------------------
// mawg_mod_unit: bit-serial restoring remainder
// Shifts in one dividend bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module mawg_mod_unit #(
    parameter int DIV_BITS = 33
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mawg_pkg::DRAW_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0]            i_divisor,
    output logic                           o_done,
    output logic [DIV_BITS-1:0]            o_remainder
);
    import mawg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DRAW_BITS-1:0] r_quo;
    logic [DIV_BITS-1:0]  r_div;
    logic [DIV_BITS-1:0]  r_rem;

    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    div_ext;
    logic [DIV_BITS-1:0]  n_rem;

    always_comb begin
        trial   = {r_rem, r_quo[DRAW_BITS-1]};
        div_ext = {1'b0, r_div};
        if (trial >= div_ext) begin
            n_rem = DIV_BITS'(trial - div_ext);
        end else begin
            n_rem = DIV_BITS'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= r_quo << 1;
            r_cnt <= r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(DRAW_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

@@ rtl/markov_address_walk_generator_core.sv @@
// ----------------------------------------------------------------------------
// markov_address_walk_generator_core: synthetic address trace generator
// Walks a word index through a region in increment, decrement or random mode
// and picks the next mode from an xorshift64* draw against per-mode thresholds.
// ----------------------------------------------------------------------------
// One word in gives one word out. Each xorshift64* draw runs through a
// bit-serial multiplier and the random-mode modulo through a bit-serial
// remainder unit. A random step makes two draws and one modulo; an increment
// or decrement step makes one draw. A new word is taken once the previous one
// has reached the output register, so a result waiting there does not hold
// the input. Configuration registers are written whenever a write is offered,
// as the channel is always ready; a seed write also reloads the generator
// state.
module markov_address_walk_generator_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mawg_in_if.sink     i_in,
    mawg_out_if.source  o_out,
    mawg_cfg_if.sink    i_cfg
);
    import mawg_pkg::*;

    localparam int SIZE_BITS = (INDEX_BITS + 1 > SIZE_FIELD_BITS) ? INDEX_BITS + 1
                                                                  : SIZE_FIELD_BITS;
    localparam logic [SIZE_BITS-1:0] FULL_SIZE = {{(SIZE_BITS-1){1'b0}}, 1'b1} << INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAW_IDX,
        S_MUL_IDX,
        S_MOD,
        S_DRAW_MODE,
        S_MUL_MODE,
        S_OUT
    } t_state;

    t_state                     r_state;
    t_mode                      r_mode;
    logic [DRAW_BITS-1:0]       r_rng;
    logic [ADDR_BITS-1:0]       r_region_base;
    logic [SIZE_FIELD_BITS-1:0] r_region_words;
    logic [DRAW_BITS-1:0]       r_thr_inc;
    logic [DRAW_BITS-1:0]       r_thr_dec;
    logic [DRAW_BITS-1:0]       r_thr_rand;
    logic [INDEX_BITS-1:0]      r_prev;
    logic [SIZE_BITS-1:0]       r_size;
    logic [INDEX_BITS-1:0]      r_idx;
    logic                       r_out_valid;
    logic [WORD_BITS-1:0]       r_out_idx;
    logic [ADDR_BITS-1:0]       r_out_addr;
    t_mode                      r_out_mode;

    logic [DRAW_BITS-1:0]       n_rng;
    logic [SIZE_BITS-1:0]       words_ext;
    logic [SIZE_BITS-1:0]       n_size;
    logic [SIZE_BITS-1:0]       inc_sum;
    logic [INDEX_BITS-1:0]      n_walk_idx;
    logic [INDEX_BITS-1:0]      rem_idx;
    logic [INDEX_BITS-1:0]      n_rand_idx;
    logic [DRAW_BITS-1:0]       thr;
    logic [PROB_BITS-1:0]       draw_hi;
    t_mode                      n_next_mode;
    logic [ADDR_BITS-1:0]       n_addr;
    logic                       out_free;
    logic                       in_take;
    logic                       cfg_take;

    logic                       mul_start;
    logic                       mul_done;
    logic [DRAW_BITS-1:0]       mul_product;
    logic                       mod_start;
    logic                       mod_done;
    logic [SIZE_BITS-1:0]       mod_rem;

    assign in_take   = i_in.valid && i_in.ready;
    assign cfg_take  = i_cfg.valid && i_cfg.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign mul_start = (r_state == S_DRAW_IDX) || (r_state == S_DRAW_MODE);
    assign mod_start = (r_state == S_MUL_IDX) && mul_done;

    always_comb begin
        n_rng     = xs_step(r_rng);
        words_ext = SIZE_BITS'(r_region_words);
        // zero or oversized region falls back to the full index space
        if (words_ext == '0 || words_ext >= FULL_SIZE) begin
            n_size = FULL_SIZE;
        end else begin
            n_size = words_ext;
        end

        inc_sum = SIZE_BITS'(r_prev) + SIZE_BITS'(1);
        case (r_mode)
            MODE_INC: begin
                n_walk_idx = (inc_sum >= r_size) ? '0 : INDEX_BITS'(inc_sum);
                thr        = r_thr_inc;
            end
            MODE_DEC: begin
                n_walk_idx = (r_prev == '0) ? INDEX_BITS'(r_size - SIZE_BITS'(1))
                                            : r_prev - INDEX_BITS'(1);
                thr        = r_thr_dec;
            end
            default: begin
                n_walk_idx = r_prev;
                thr        = r_thr_rand;
            end
        endcase

        rem_idx    = INDEX_BITS'(mod_rem);
        n_rand_idx = {rem_idx[INDEX_BITS-1:ALIGN_BITS], {ALIGN_BITS{1'b0}}};

        draw_hi = mul_product[DRAW_BITS-1 -: PROB_BITS];
        if (draw_hi < thr[PROB_BITS-1:0]) begin
            n_next_mode = MODE_INC;
        end else if (draw_hi < thr[DRAW_BITS-1 -: PROB_BITS]) begin
            n_next_mode = MODE_DEC;
        end else begin
            n_next_mode = MODE_RAND;
        end

        n_addr = r_region_base + ADDR_BITS'({r_idx, {WORD_SHIFT{1'b0}}});
    end

    mawg_mix_mul u_mix_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_operand (n_rng),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    mawg_mod_unit #(
        .DIV_BITS (SIZE_BITS)
    ) u_mod_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (mul_product),
        .i_divisor   (r_size),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= '0;
            r_region_words <= REGION_WORDS_RESET;
            r_thr_inc      <= '0;
            r_thr_dec      <= '0;
            r_thr_rand     <= '0;
        end else if (cfg_take) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_REGION_BASE:  r_region_base  <= i_cfg.data;
                REG_REGION_WORDS: r_region_words <= i_cfg.data[SIZE_FIELD_BITS-1:0];
                REG_THR_INC:      r_thr_inc      <= i_cfg.data;
                REG_THR_DEC:      r_thr_dec      <= i_cfg.data;
                REG_THR_RAND:     r_thr_rand     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_RAND;
            r_rng       <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_take && t_cfg_reg'(i_cfg.index) == REG_SEED_INIT) begin
                r_rng <= seed_value(i_cfg.data);
            end else if (mul_start) begin
                r_rng <= n_rng;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_prev  <= INDEX_BITS'(i_in.prev_word_index);
                        r_size  <= n_size;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_idx <= n_walk_idx;
                    if (r_mode == MODE_INC || r_mode == MODE_DEC) begin
                        r_state <= S_DRAW_MODE;
                    end else begin
                        r_state <= S_DRAW_IDX;
                    end
                end
                S_DRAW_IDX: begin
                    r_state <= S_MUL_IDX;
                end
                S_MUL_IDX: begin
                    if (mul_done) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_idx   <= n_rand_idx;
                        r_state <= S_DRAW_MODE;
                    end
                end
                S_DRAW_MODE: begin
                    r_state <= S_MUL_MODE;
                end
                S_MUL_MODE: begin
                    if (mul_done) begin
                        r_mode  <= n_next_mode;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_idx  <= WORD_BITS'(r_idx);
                        r_out_addr <= n_addr;
                        r_out_mode <= r_mode;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.next_word_index = r_out_idx;
    assign o_out.next_address    = r_out_addr;
    assign o_out.next_mode       = r_out_mode;

`ifndef ASSERT_OFF
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result word appeared outside the output step");

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL_IDX || r_state == S_MUL_MODE))
        else $error("multiplier finished with no draw pending");

    a_rand_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && mod_done) |=> (r_idx[ALIGN_BITS-1:0] == '0))
        else $error("random index not aligned to eight words");
`endif

endmodule
